// ----- hdl/waypoint_follower_speed_controller_macros.svh -----
// Assertion macros shared by the waypoint follower RTL.
`ifndef WAYPOINT_FOLLOWER_SPEED_CONTROLLER_MACROS_SVH
`define WAYPOINT_FOLLOWER_SPEED_CONTROLLER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define WFSC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define WFSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/wfsc_pkg.sv -----
// Types, constants and helpers of the waypoint follower speed controller.
package wfsc_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int SPEED_W         = 16;
   localparam int ANGLE_W         = 16;
   localparam int DIFF_W          = 17;
   localparam int SQ_W            = 34;
   localparam int CORDIC_W        = 28;
   localparam int CORDIC_PRESCALE = 8;
   localparam int ITER_CNT_W      = 5;
   localparam int ROT_W           = 13;
   localparam int ROT_SHIFT       = 15;
   localparam int ROT_LIMIT       = 2048;
   localparam int LIM_W           = 19;
   localparam int DIST_W          = 16;
   localparam int TARGET_W        = 11;
   localparam int THRESH_W        = 12;
   localparam int MAX_SPEED_W     = 15;
   localparam int PATH_LEN_W      = 11;
   localparam int MODE_W          = 3;
   localparam int ENTRY_W         = 10;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int WP_W            = 2 * COORD_WIDTH + SPEED_W;

   localparam logic [SQ_W-1:0]          ROOT_FIRST_BIT = SQ_W'(64'h1_0000_0000);
   localparam logic [ITER_CNT_W-1:0]    ITER_LAST      = ITER_CNT_W'(16);
   localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = 16'sh4000;
   localparam logic signed [31:0]       ROT_GAIN       = 32'sd25736;
   localparam logic signed [31:0]       ROT_ROUND      = 32'sd16384;

   localparam logic [THRESH_W-1:0]    THRESH_RESET    = THRESH_W'(205);
   localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RESET = MAX_SPEED_W'(2048);
   localparam logic [PATH_LEN_W-1:0]  PATH_LEN_RESET  = '0;

   // CORDIC arctangent steps, binary angle units
   localparam logic [ANGLE_W-1:0] ANGLE_STEP [16] = '{
      16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
      16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0
   };

   localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PROCEED = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POSE    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_POS_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATH_LENGTH   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SQUARE,
      ST_ITER,
      ST_DECIDE,
      ST_LIMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]             mode;
      logic [ENTRY_W-1:0]            entry_index;
      logic signed [COORD_WIDTH-1:0] waypoint_x;
      logic signed [COORD_WIDTH-1:0] waypoint_y;
      logic signed [SPEED_W-1:0]     waypoint_speed;
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [ANGLE_W-1:0]     heading;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic                      running;
      logic [DIST_W-1:0]         distance;
      logic [TARGET_W-1:0]       target_now;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [SPEED_W-1:0]     v;
   } wp_type;

   function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [LIM_W-1:0] val);
      logic signed [LIM_W-1:0] hi;
      logic signed [LIM_W-1:0] lo;
      hi = LIM_W'(32767);
      lo = -LIM_W'(32768);
      if (val > hi) begin
         return 16'sh7FFF;
      end else if (val < lo) begin
         return 16'sh8000;
      end
      return SPEED_W'(val);
   endfunction

endpackage

// ----- hdl/wfsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module wfsc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/waypoint_follower_speed_controller.sv -----
// Top level of the differential-drive waypoint follower speed controller.
//
// The block takes one request beat at a time and answers each with exactly one
// response beat. Load, start, stop and proceed requests, and a pose request when
// no waypoint is current, go from acceptance to ST_DONE and into the response
// register once it is free. A pose request with a current waypoint runs through
// a table read issued at acceptance, ST_FETCH and ST_SQUARE that square and sum
// the offsets, 17 passes through one shared iteration step (a one-bit-per-pass
// square root of dx*dx + dy*dy, with a 16-pass CORDIC vectoring rotation for the
// bearing riding along in the same passes), a decision step that advances the
// target and scales the bearing error into a rotation speed, a limit step for
// the translation speed (skipped at path end), and ST_DONE, which loads the
// response register when free. req_ready is high only while the sequencer is
// idle; a finished response may still sit in the response register then, so the
// next request is taken without waiting for the consumer. The waypoint table is
// a RAM of MAX_WAYPOINTS entries with no reset: slots must be loaded before a
// path that uses them is run. Configuration writes are always taken
// (csr_ready is tied high) and are meant to arrive only while the block is idle.
`include "waypoint_follower_speed_controller_macros.svh"

module waypoint_follower_speed_controller #(
   parameter int MAX_WAYPOINTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wfsc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wfsc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wfsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wfsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_WAYPOINTS);

   // sequencer and architectural state
   wfsc_pkg::state_type state_ff, state_in;
   wfsc_pkg::req_type   item_ff, item_in;
   logic [wfsc_pkg::TARGET_W-1:0]    target_ff, target_in;
   logic                             active_ff, active_in;
   logic [wfsc_pkg::THRESH_W-1:0]    thresh_ff, thresh_in;
   logic [wfsc_pkg::MAX_SPEED_W-1:0] max_speed_ff, max_speed_in;
   logic [wfsc_pkg::PATH_LEN_W-1:0]  path_len_ff, path_len_in;

   // pose datapath
   logic signed [wfsc_pkg::DIFF_W-1:0]   dx_ff, dx_in;
   logic signed [wfsc_pkg::DIFF_W-1:0]   dy_ff, dy_in;
   logic [wfsc_pkg::SQ_W-1:0]            sq_ff, sq_in;
   logic [wfsc_pkg::SQ_W-1:0]            root_ff, root_in;
   logic [wfsc_pkg::SQ_W-1:0]            bit_ff, bit_in;
   logic signed [wfsc_pkg::CORDIC_W-1:0] cx_ff, cx_in;
   logic signed [wfsc_pkg::CORDIC_W-1:0] cy_ff, cy_in;
   logic signed [wfsc_pkg::ANGLE_W-1:0]  z_ff, z_in;
   logic                                 zero_ff, zero_in;
   logic [wfsc_pkg::ITER_CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [wfsc_pkg::ROT_W-1:0]    rot_ff, rot_in;
   wfsc_pkg::rsp_type                    res_ff, res_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   wfsc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // RAM port
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [wfsc_pkg::WP_W-1:0] ram_wr_data;
   logic                    ram_rd_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [wfsc_pkg::WP_W-1:0] ram_rd_data;
   wfsc_pkg::wp_type        wp_rd;
   wfsc_pkg::wp_type        wp_wr;

   // combinational helpers
   logic                                 req_fire;
   logic                                 out_free;
   logic                                 slot_ok;
   logic [wfsc_pkg::TARGET_W-1:0]        len_use;
   logic signed [wfsc_pkg::DIFF_W-1:0]   dx_calc;
   logic signed [wfsc_pkg::DIFF_W-1:0]   dy_calc;
   logic signed [wfsc_pkg::SQ_W-1:0]     dx_sq;
   logic signed [wfsc_pkg::SQ_W-1:0]     dy_sq;
   logic signed [wfsc_pkg::CORDIC_W-1:0] ext_x;
   logic signed [wfsc_pkg::CORDIC_W-1:0] ext_y;
   logic signed [wfsc_pkg::CORDIC_W-1:0] pre_x;
   logic signed [wfsc_pkg::CORDIC_W-1:0] pre_y;
   logic signed [wfsc_pkg::ANGLE_W-1:0]  pre_z;
   logic [3:0]                           sh;
   logic signed [wfsc_pkg::CORDIC_W-1:0] xs;
   logic signed [wfsc_pkg::CORDIC_W-1:0] ys;
   logic [wfsc_pkg::SQ_W-1:0]            sq_trial;
   logic                                 sq_take;
   logic [wfsc_pkg::DIST_W-1:0]          dist_sat;
   logic                                 adv;
   logic [wfsc_pkg::TARGET_W-1:0]        tgt_next;
   logic                                 in_range;
   logic signed [wfsc_pkg::ANGLE_W-1:0]  bearing;
   logic signed [wfsc_pkg::ANGLE_W-1:0]  err;
   logic signed [31:0]                   rot_prod;
   logic signed [31:0]                   rot_sh;
   logic signed [wfsc_pkg::ROT_W-1:0]    rot_clamp;
   logic signed [wfsc_pkg::LIM_W-1:0]    lim_v0;
   logic signed [wfsc_pkg::LIM_W-1:0]    lim_r;
   logic signed [wfsc_pkg::LIM_W-1:0]    lim_m;
   logic signed [wfsc_pkg::LIM_W-1:0]    lim_v;
   logic                                 lim_same;

   wfsc_ram #(
      .WIDTH (wfsc_pkg::WP_W),
      .DEPTH (MAX_WAYPOINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign wp_rd = ram_rd_data;

   // handshakes
   assign req_ready = (state_ff == wfsc_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // path length in use never exceeds the table depth
   assign len_use = (32'(path_len_ff) > 32'(MAX_WAYPOINTS)) ? wfsc_pkg::TARGET_W'(MAX_WAYPOINTS)
                                                            : path_len_ff;
   assign slot_ok = (32'(req_data.entry_index) < 32'(MAX_WAYPOINTS));

   // offsets and their squares (one multiply per cycle)
   assign dx_calc = $signed({wp_rd.x[wfsc_pkg::COORD_WIDTH-1], wp_rd.x})
                  - $signed({item_ff.pos_x[wfsc_pkg::COORD_WIDTH-1], item_ff.pos_x});
   assign dy_calc = $signed({wp_rd.y[wfsc_pkg::COORD_WIDTH-1], wp_rd.y})
                  - $signed({item_ff.pos_y[wfsc_pkg::COORD_WIDTH-1], item_ff.pos_y});
   assign dx_sq   = dx_calc * dx_calc;
   assign dy_sq   = dy_ff * dy_ff;

   // CORDIC start: fold the left half-plane into the right one
   assign ext_x = wfsc_pkg::CORDIC_W'(dx_ff);
   assign ext_y = wfsc_pkg::CORDIC_W'(dy_ff);

   always_comb begin
      pre_x = ext_x;
      pre_y = ext_y;
      pre_z = '0;
      if (ext_x < 0) begin
         if (ext_y >= 0) begin
            pre_x = ext_y;
            pre_y = -ext_x;
            pre_z = wfsc_pkg::ANGLE_QUARTER;
         end else begin
            pre_x = -ext_y;
            pre_y = ext_x;
            pre_z = -wfsc_pkg::ANGLE_QUARTER;
         end
      end
   end

   // shared iteration step: one root bit and one CORDIC micro-rotation
   assign sh       = cnt_ff[3:0];
   assign xs       = cx_ff >>> sh;
   assign ys       = cy_ff >>> sh;
   assign sq_trial = root_ff + bit_ff;
   assign sq_take  = (sq_ff >= sq_trial);

   // decision: arrival test, bearing error and rotation speed
   assign dist_sat = root_ff[wfsc_pkg::DIST_W] ? '1 : root_ff[wfsc_pkg::DIST_W-1:0];
   assign adv      = (root_ff < wfsc_pkg::SQ_W'(thresh_ff));
   assign tgt_next = target_ff + wfsc_pkg::TARGET_W'(adv);
   assign in_range = (tgt_next < len_use);
   assign bearing  = zero_ff ? '0 : z_ff;
   assign err      = bearing - item_ff.heading;
   assign rot_prod = 32'(err) * wfsc_pkg::ROT_GAIN;
   assign rot_sh   = (rot_prod + wfsc_pkg::ROT_ROUND) >>> wfsc_pkg::ROT_SHIFT;

   always_comb begin
      if (rot_sh > wfsc_pkg::ROT_LIMIT) begin
         rot_clamp = wfsc_pkg::ROT_W'(wfsc_pkg::ROT_LIMIT);
      end else if (rot_sh < -wfsc_pkg::ROT_LIMIT) begin
         rot_clamp = wfsc_pkg::ROT_W'(-wfsc_pkg::ROT_LIMIT);
      end else begin
         rot_clamp = wfsc_pkg::ROT_W'(rot_sh);
      end
   end

   // translation limit: keep both wheels within +-max_speed
   assign lim_v0 = wfsc_pkg::LIM_W'(wp_rd.v);
   assign lim_r  = wfsc_pkg::LIM_W'(rot_ff);
   assign lim_m  = $signed({{(wfsc_pkg::LIM_W - wfsc_pkg::MAX_SPEED_W){1'b0}}, max_speed_ff});

   always_comb begin
      lim_v    = lim_v0;
      lim_same = ((lim_v0 > 0) && (lim_r > 0)) || ((lim_v0 < 0) && (lim_r < 0));
      if (lim_same) begin
         if (lim_v0 + lim_r > lim_m) begin
            lim_v = lim_m - lim_r;
         end else if (lim_v0 + lim_r < -lim_m) begin
            lim_v = -lim_m - lim_r;
         end
      end else begin
         if (lim_v0 - lim_r > lim_m) begin
            lim_v = lim_m + lim_r;
         end else if (lim_v0 - lim_r < -lim_m) begin
            lim_v = -lim_m + lim_r;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wfsc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if ((req_data.mode == wfsc_pkg::MODE_POSE) && (target_ff < len_use)) begin
                  state_in = wfsc_pkg::ST_FETCH;
               end else begin
                  state_in = wfsc_pkg::ST_DONE;
               end
            end
         end
         wfsc_pkg::ST_FETCH:  state_in = wfsc_pkg::ST_SQUARE;
         wfsc_pkg::ST_SQUARE: state_in = wfsc_pkg::ST_ITER;
         wfsc_pkg::ST_ITER: begin
            if (cnt_ff == wfsc_pkg::ITER_LAST) begin
               state_in = wfsc_pkg::ST_DECIDE;
            end
         end
         wfsc_pkg::ST_DECIDE: begin
            state_in = in_range ? wfsc_pkg::ST_LIMIT : wfsc_pkg::ST_DONE;
         end
         wfsc_pkg::ST_LIMIT: state_in = wfsc_pkg::ST_DONE;
         wfsc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = wfsc_pkg::ST_IDLE;
            end
         end
         default: state_in = wfsc_pkg::ST_IDLE;
      endcase
   end

   // table port controls
   always_comb begin
      wp_wr.x     = req_data.waypoint_x;
      wp_wr.y     = req_data.waypoint_y;
      wp_wr.v     = req_data.waypoint_speed;
      ram_wr_data = wp_wr;
      ram_wr_addr = AW'(req_data.entry_index);
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(target_ff);
      case (state_ff)
         wfsc_pkg::ST_IDLE: begin
            ram_wr_en = req_fire && (req_data.mode == wfsc_pkg::MODE_LOAD) && slot_ok;
            ram_rd_en = req_fire;
         end
         wfsc_pkg::ST_DECIDE: begin
            // fetch the speed of the waypoint now targeted
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(tgt_next);
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   // datapath and architectural next values
   always_comb begin
      item_in      = item_ff;
      target_in    = target_ff;
      active_in    = active_ff;
      thresh_in    = thresh_ff;
      max_speed_in = max_speed_ff;
      path_len_in  = path_len_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      zero_in      = zero_ff;
      cnt_in       = cnt_ff;
      rot_in       = rot_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            wfsc_pkg::CSR_POS_THRESHOLD: thresh_in    = csr_wdata[wfsc_pkg::THRESH_W-1:0];
            wfsc_pkg::CSR_MAX_SPEED:     max_speed_in = csr_wdata[wfsc_pkg::MAX_SPEED_W-1:0];
            wfsc_pkg::CSR_PATH_LENGTH:   path_len_in  = csr_wdata[wfsc_pkg::PATH_LEN_W-1:0];
            default:                     thresh_in    = thresh_ff;
         endcase
      end

      case (state_ff)
         wfsc_pkg::ST_IDLE: begin
            if (req_fire) begin
               item_in = req_data;
               case (req_data.mode)
                  wfsc_pkg::MODE_START: begin
                     target_in = '0;
                     active_in = 1'b1;
                  end
                  wfsc_pkg::MODE_STOP:    active_in = 1'b0;
                  wfsc_pkg::MODE_PROCEED: active_in = 1'b1;
                  wfsc_pkg::MODE_POSE: begin
                     // no current waypoint: drop out of the maneuver
                     if (target_ff >= len_use) begin
                        active_in = 1'b0;
                     end
                  end
                  default: active_in = active_ff;
               endcase
               res_in.left_speed  = '0;
               res_in.right_speed = '0;
               res_in.distance    = '0;
               res_in.running     = active_in;
               res_in.target_now  = target_in;
            end
         end
         wfsc_pkg::ST_FETCH: begin
            dx_in = dx_calc;
            dy_in = dy_calc;
            sq_in = $unsigned(dx_sq);
         end
         wfsc_pkg::ST_SQUARE: begin
            sq_in   = sq_ff + $unsigned(dy_sq);
            root_in = '0;
            bit_in  = wfsc_pkg::ROOT_FIRST_BIT;
            cx_in   = pre_x <<< wfsc_pkg::CORDIC_PRESCALE;
            cy_in   = pre_y <<< wfsc_pkg::CORDIC_PRESCALE;
            z_in    = pre_z;
            zero_in = (dx_ff == '0) && (dy_ff == '0);
            cnt_in  = '0;
         end
         wfsc_pkg::ST_ITER: begin
            if (sq_take) begin
               sq_in   = sq_ff - sq_trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            // the rotation runs one pass short of the root
            if (cnt_ff != wfsc_pkg::ITER_LAST) begin
               if (!cy_ff[wfsc_pkg::CORDIC_W-1]) begin
                  cx_in = cx_ff + ys;
                  cy_in = cy_ff - xs;
                  z_in  = z_ff + $signed(wfsc_pkg::ANGLE_STEP[sh]);
               end else begin
                  cx_in = cx_ff - ys;
                  cy_in = cy_ff + xs;
                  z_in  = z_ff - $signed(wfsc_pkg::ANGLE_STEP[sh]);
               end
            end
            cnt_in = cnt_ff + 1'b1;
         end
         wfsc_pkg::ST_DECIDE: begin
            target_in          = tgt_next;
            rot_in             = rot_clamp;
            active_in          = in_range ? active_ff : 1'b0;
            res_in.left_speed  = '0;
            res_in.right_speed = '0;
            res_in.distance    = dist_sat;
            res_in.running     = in_range ? active_ff : 1'b0;
            res_in.target_now  = tgt_next;
         end
         wfsc_pkg::ST_LIMIT: begin
            res_in.left_speed  = wfsc_pkg::sat16(lim_v + lim_r);
            res_in.right_speed = wfsc_pkg::sat16(lim_v - lim_r);
         end
         default: begin
            res_in = res_ff;
         end
      endcase

      // response register: load when free, otherwise drain on ready
      if ((state_ff == wfsc_pkg::ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfsc_pkg::ST_IDLE;
         target_ff    <= '0;
         active_ff    <= 1'b0;
         thresh_ff    <= wfsc_pkg::THRESH_RESET;
         max_speed_ff <= wfsc_pkg::MAX_SPEED_RESET;
         path_len_ff  <= wfsc_pkg::PATH_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         active_ff    <= active_in;
         thresh_ff    <= thresh_in;
         max_speed_ff <= max_speed_in;
         path_len_ff  <= path_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sq_ff       <= sq_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      z_ff        <= z_in;
      zero_ff     <= zero_in;
      cnt_ff      <= cnt_in;
      rot_ff      <= rot_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a pose beat with a current waypoint always goes to the table read
   `WFSC_ASSERT_NEXT(a_pose_fetch, req_fire && (req_data.mode == wfsc_pkg::MODE_POSE) && (target_ff < len_use), state_ff == wfsc_pkg::ST_FETCH, "pose beat did not start a fetch")
   // iteration counter never runs past the last pass
   `WFSC_ASSERT_SAME(a_iter_bound, state_ff == wfsc_pkg::ST_ITER, cnt_ff <= wfsc_pkg::ITER_LAST, "iteration counter overran")
   // a decision moves the target by at most one waypoint
   `WFSC_ASSERT_NEXT(a_target_step, state_ff == wfsc_pkg::ST_DECIDE, (target_ff == $past(target_ff)) || (target_ff == $past(target_ff) + 11'd1), "target moved by more than one")
   // speed limiting only follows a decision that found a waypoint
   `WFSC_ASSERT_SAME(a_limit_entry, state_ff == wfsc_pkg::ST_LIMIT, $past(state_ff) == wfsc_pkg::ST_DECIDE, "limit state entered out of order")

endmodule
